>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, masked while rst_n is low.
`define SSPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define SSPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/sspq_pkg.sv
package sspq_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] status_t;

    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_POP    = 2'd2;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_EMPTY     = 2'd3;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned COUNT_W = 5;

    typedef struct packed {
        cmd_t               command;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] data_in;
    } cmd_beat_t;

    typedef struct packed {
        status_t            status;
        logic [FIELD_W-1:0] data_out;
        logic [FIELD_W-1:0] key_out;
        logic [FIELD_W-1:0] head_key;
        logic               head_valid;
        logic [COUNT_W-1:0] entry_count;
    } rsp_beat_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic go;
        cmd_t command;
        logic full;
        logic found;
        logic nonempty;
    } cell_ctl_t;

    // Per-cell status seen by neighbors and by the top level.
    typedef struct packed {
        logic valid;
        logic ins_pt;
        logic ge;
        logic match;
    } cell_flags_t;

endpackage

>>> hw/rtl/sspq_cmd_if.sv
interface sspq_cmd_if;
    import sspq_pkg::*;

    logic      valid;
    logic      ready;
    cmd_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/sspq_rsp_if.sv
interface sspq_rsp_if;
    import sspq_pkg::*;

    logic      valid;
    logic      ready;
    rsp_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/sspq_cell.sv
module sspq_cell #(
    parameter int unsigned KEY_BITS  = 32,
    parameter int unsigned DATA_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sspq_pkg::cell_ctl_t    ctl,
    input  logic [KEY_BITS-1:0]    new_key,
    input  logic [DATA_BITS-1:0]   new_data,
    input  sspq_pkg::cell_flags_t  left_flags,
    input  logic [KEY_BITS-1:0]    left_key,
    input  logic [DATA_BITS-1:0]   left_data,
    input  sspq_pkg::cell_flags_t  right_flags,
    input  logic [KEY_BITS-1:0]    right_key,
    input  logic [DATA_BITS-1:0]   right_data,
    output sspq_pkg::cell_flags_t  flags,
    output logic [KEY_BITS-1:0]    key_q,
    output logic [DATA_BITS-1:0]   data_q,
    output logic                   valid_next,
    output logic [KEY_BITS-1:0]    key_next
);
    import sspq_pkg::*;

    logic                 valid_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [DATA_BITS-1:0] data_reg;
    logic [DATA_BITS-1:0] data_next;

    // The new key goes at or before this slot when the slot is empty or the key sorts strictly below it.
    assign flags.valid  = valid_reg;
    assign flags.ins_pt = !valid_reg || (new_key < key_reg);
    assign flags.ge     = valid_reg && (key_reg >= new_key);
    assign flags.match  = valid_reg && (key_reg == new_key);

    assign key_q  = key_reg;
    assign data_q = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        if (ctl.go)
        begin
            case (ctl.command)
                CMD_INSERT:
                begin
                    if (!ctl.full && flags.ins_pt)
                    begin
                        if (left_flags.ins_pt)
                        begin
                            // shift right: take the left neighbor
                            valid_next = left_flags.valid;
                            key_next   = left_key;
                            data_next  = left_data;
                        end
                        else
                        begin
                            valid_next = 1'b1;
                            key_next   = new_key;
                            data_next  = new_data;
                        end
                    end
                end
                CMD_REMOVE:
                begin
                    if (ctl.found && flags.ge)
                    begin
                        valid_next = right_flags.valid;
                        key_next   = right_key;
                        data_next  = right_data;
                    end
                end
                CMD_POP:
                begin
                    if (ctl.nonempty)
                    begin
                        valid_next = right_flags.valid;
                        key_next   = right_key;
                        data_next  = right_data;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

endmodule

>>> hw/rtl/stable_sorted_priority_queue_top.sv
// The result beat for a command is registered and appears in the cycle after the command beat is taken.
// Throughput: 1 command per cycle while the result side takes each beat; every cell compares against the
// broadcast key and shifts with its neighbor in the same cycle, so no command waits on another's cell updates.
// Reset: rst_n (async, active low) empties the list and drops any pending result beat;
// stored keys and data tags are not cleared and are never read before being written.
module stable_sorted_priority_queue_top #(
    parameter int unsigned DEPTH     = 16,
    parameter int unsigned KEY_BITS  = 32,
    parameter int unsigned DATA_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    sspq_cmd_if.sink    cmd,
    sspq_rsp_if.source  rsp
);
    import sspq_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    `include "assert_macros.svh"

    // Handshake and output register.
    logic      rsp_valid_reg;
    rsp_beat_t rsp_beat_reg;
    rsp_beat_t rsp_beat_next;
    logic      go;

    // Hold the result beat until taken; take a new command in the same cycle it leaves.
    assign cmd.ready   = !rsp_valid_reg || rsp.ready;
    assign go          = cmd.valid && cmd.ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_beat_reg;

    logic [KEY_BITS-1:0]  new_key;
    logic [DATA_BITS-1:0] new_data;

    assign new_key  = KEY_BITS'(cmd.payload.key);
    assign new_data = DATA_BITS'(cmd.payload.data_in);

    // Cell chain.
    cell_ctl_t            ctl;
    cell_flags_t          cell_flags [DEPTH];
    logic [KEY_BITS-1:0]  cell_key   [DEPTH];
    logic [DATA_BITS-1:0] cell_data  [DEPTH];
    logic [KEY_BITS-1:0]  cell_key_next [DEPTH];
    logic [DEPTH-1:0]     cell_valid_next;
    logic [DEPTH-1:0]     valid_vec;
    logic [DEPTH-1:0]     match_vec;
    logic [DEPTH-1:0]     rem_sel;

    logic full;
    logic nonempty;
    logic found;

    assign full     = valid_vec[DEPTH-1];
    assign nonempty = valid_vec[0];
    assign found    = |match_vec;

    assign ctl.go       = go;
    assign ctl.command  = cmd.payload.command;
    assign ctl.full     = full;
    assign ctl.found    = found;
    assign ctl.nonempty = nonempty;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_flags_t          lf;
        cell_flags_t          rf;
        logic [KEY_BITS-1:0]  lk;
        logic [KEY_BITS-1:0]  rk;
        logic [DATA_BITS-1:0] ld;
        logic [DATA_BITS-1:0] rd;

        if (i == 0)
        begin : g_head
            assign lf = '0;
            assign lk = '0;
            assign ld = '0;
            // The head is the first match when it matches at all.
            assign rem_sel[i] = match_vec[i];
        end
        else
        begin : g_mid
            assign lf = cell_flags[i-1];
            assign lk = cell_key[i-1];
            assign ld = cell_data[i-1];
            // Sorted list: the first match is the first slot at or above the key.
            assign rem_sel[i] = match_vec[i] && !cell_flags[i-1].ge;
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign rf = '0;
            assign rk = '0;
            assign rd = '0;
        end
        else
        begin : g_body
            assign rf = cell_flags[i+1];
            assign rk = cell_key[i+1];
            assign rd = cell_data[i+1];
        end

        assign valid_vec[i] = cell_flags[i].valid;
        assign match_vec[i] = cell_flags[i].match;

        sspq_cell #(
            .KEY_BITS  (KEY_BITS),
            .DATA_BITS (DATA_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_key     (new_key),
            .new_data    (new_data),
            .left_flags  (lf),
            .left_key    (lk),
            .left_data   (ld),
            .right_flags (rf),
            .right_key   (rk),
            .right_data  (rd),
            .flags       (cell_flags[i]),
            .key_q       (cell_key[i]),
            .data_q      (cell_data[i]),
            .valid_next  (cell_valid_next[i]),
            .key_next    (cell_key_next[i])
        );
    end

    // Removed entry of a remove: OR of the one-hot selected slot.
    logic [KEY_BITS-1:0]  sel_key;
    logic [DATA_BITS-1:0] sel_data;

    always_comb
    begin
        sel_key  = '0;
        sel_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (rem_sel[i])
            begin
                sel_key  = sel_key | cell_key[i];
                sel_data = sel_data | cell_data[i];
            end
        end
    end

    // Occupancy and result beat.
    logic [CNT_W-1:0]     occ_reg;
    logic [CNT_W-1:0]     occ_next;
    status_t              status;
    logic [KEY_BITS-1:0]  rm_key;
    logic [DATA_BITS-1:0] rm_data;

    always_comb
    begin
        occ_next = occ_reg;
        status   = ST_OK;
        rm_key   = '0;
        rm_data  = '0;
        case (cmd.payload.command)
            CMD_INSERT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    occ_next = occ_reg + 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (found)
                begin
                    rm_key   = sel_key;
                    rm_data  = sel_data;
                    occ_next = occ_reg - 1'b1;
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            CMD_POP:
            begin
                if (nonempty)
                begin
                    rm_key   = cell_key[0];
                    rm_data  = cell_data[0];
                    occ_next = occ_reg - 1'b1;
                end
                else
                begin
                    status = ST_EMPTY;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_beat_next.status      = status;
        rsp_beat_next.data_out    = FIELD_W'(rm_data);
        rsp_beat_next.key_out     = FIELD_W'(rm_key);
        rsp_beat_next.head_key    = cell_valid_next[0] ? FIELD_W'(cell_key_next[0]) : '0;
        rsp_beat_next.head_valid  = cell_valid_next[0];
        rsp_beat_next.entry_count = COUNT_W'(occ_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            occ_reg       <= '0;
        end
        else
        begin
            if (go)
            begin
                rsp_valid_reg <= 1'b1;
                occ_reg       <= occ_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload register: load only with a new beat.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rsp_beat_reg <= rsp_beat_next;
        end
    end

    // Checks.
    `SSPQ_ASSERT(a_occ_tracks_cells, ($countones(valid_vec) == occ_reg), "occupancy disagrees with cell valid bits")
    `SSPQ_ASSERT(a_list_compact, ((valid_vec & (valid_vec + 1'b1)) == '0), "valid cells are not packed at the head")
    `SSPQ_ASSERT(a_beat_follows, (go |=> rsp_valid_reg), "accepted command produced no result beat")
    `SSPQ_ASSERT_ALWAYS(a_reset_empty, (!rst_n |-> (occ_reg == '0 && !rsp_valid_reg)), "list not empty in reset")

endmodule

>>> tb/sorted_queue_checker.sv
`timescale 1ns / 1ps

module sorted_queue_checker (
    input  logic        clk,
    input  logic        rst_n,
    sspq_cmd_if         cmd,
    sspq_rsp_if         rsp,
    output int unsigned fail_count,
    output int unsigned answers_owed
);
    import sspq_pkg::*;

    localparam int unsigned LIST_DEPTH = 16;

    // Shadow copy of the sorted list, kept compact in slots 0..list_len-1.
    logic [FIELD_W-1:0] list_keys [LIST_DEPTH];
    logic [FIELD_W-1:0] list_tags [LIST_DEPTH];
    int unsigned        list_len = 0;

    rsp_beat_t   answers_due [$];
    rsp_beat_t   oldest_answer;
    int unsigned fail_total = 0;
    int unsigned owed_total = 0;

    assign fail_count   = fail_total;
    assign answers_owed = owed_total;

    // Take the entry at pos out of the list and close the gap.
    function automatic void take_entry(input int unsigned pos, inout rsp_beat_t res);
        int unsigned i;
        res.key_out  = list_keys[pos];
        res.data_out = list_tags[pos];
        for (i = pos; i + 1 < list_len; i++)
        begin
            list_keys[i] = list_keys[i + 1];
            list_tags[i] = list_tags[i + 1];
        end
        list_len--;
    endfunction

    // Apply one command to the shadow list and return the response it earns.
    function automatic rsp_beat_t step_sorted_list(input cmd_beat_t beat);
        rsp_beat_t   res;
        int unsigned pos;
        int unsigned i;
        res        = '0;
        res.status = ST_OK;
        case (beat.command)
            CMD_INSERT:
            begin
                if (list_len >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    // Land after every equal key so equal keys leave in arrival order.
                    pos = 0;
                    while (pos < list_len && list_keys[pos] <= beat.key)
                        pos++;
                    for (i = list_len; i > pos; i--)
                    begin
                        list_keys[i] = list_keys[i - 1];
                        list_tags[i] = list_tags[i - 1];
                    end
                    list_keys[pos] = beat.key;
                    list_tags[pos] = beat.data_in;
                    list_len++;
                end
            end
            CMD_REMOVE:
            begin
                pos = 0;
                while (pos < list_len && list_keys[pos] != beat.key)
                    pos++;
                if (pos == list_len)
                    res.status = ST_NOT_FOUND;
                else
                    take_entry(pos, res);
            end
            CMD_POP:
            begin
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else
                    take_entry(0, res);
            end
            default:
            begin
                // Spare opcode: report the list untouched.
            end
        endcase
        res.head_valid  = (list_len != 0);
        res.head_key    = (list_len != 0) ? list_keys[0] : '0;
        res.entry_count = list_len[COUNT_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
                                        input logic [FIELD_W-1:0] got);
        if (got !== want)
        begin
            fail_total++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_len = 0;
            answers_due.delete();
            owed_total = 0;
        end
        else
        begin
            // A response beat at this edge always belongs to an earlier command,
            // so retire it before logging the command taken at the same edge.
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: response beat with none expected: expected none, actual %h",
                             $time, rsp.payload);
                end
                else
                begin
                    oldest_answer = answers_due.pop_front();
                    owed_total--;
                    check_field("status", FIELD_W'(oldest_answer.status),
                                FIELD_W'(rsp.payload.status));
                    check_field("data_out", oldest_answer.data_out, rsp.payload.data_out);
                    check_field("key_out", oldest_answer.key_out, rsp.payload.key_out);
                    check_field("head_key", oldest_answer.head_key, rsp.payload.head_key);
                    check_field("head_valid", FIELD_W'(oldest_answer.head_valid),
                                FIELD_W'(rsp.payload.head_valid));
                    check_field("entry_count", FIELD_W'(oldest_answer.entry_count),
                                FIELD_W'(rsp.payload.entry_count));
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                answers_due.push_back(step_sorted_list(cmd.payload));
                owed_total++;
            end
        end
    end

endmodule

>>> tb/stable_sorted_priority_queue_top_tb.sv
`timescale 1ns / 1ps

module stable_sorted_priority_queue_top_tb;
    import sspq_pkg::*;

    // The fourth opcode has no name in the package; the block treats it as a no-op.
    localparam cmd_t        CMD_NOP    = 2'd3;
    localparam int unsigned LIST_DEPTH = 16;

    logic clk;
    logic rst_n;

    sspq_cmd_if cmd_ch ();
    sspq_rsp_if rsp_ch ();

    int unsigned fail_count;
    int unsigned answers_owed;

    // Traffic shaping, shared between the command side and the response side.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    bit          hold_request  = 1'b0;

    // Keys inserted lately; removes aim at these so most of them hit.
    logic [FIELD_W-1:0] recent_keys [LIST_DEPTH];
    int unsigned        recent_wr = 0;

    stable_sorted_priority_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    sorted_queue_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_ch),
        .rsp          (rsp_ch),
        .fail_count   (fail_count),
        .answers_owed (answers_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial
    begin
        #2_400_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one command beat. Idle first when the phase asks for gaps, then
    // hold the beat until the block takes it. Returns at the accepting edge.
    task automatic offer_cmd(input cmd_t op, input logic [FIELD_W-1:0] key,
                             input logic [FIELD_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid           <= 1'b1;
        cmd_ch.payload.command <= op;
        cmd_ch.payload.key     <= key;
        cmd_ch.payload.data_in <= data;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // Mostly a small pool so duplicates and remove hits are common, some
    // extremes, the rest fully random.
    function automatic logic [FIELD_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return FIELD_W'($urandom_range(7));
        if (roll < 65)
        begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return '1;
                2:       return 32'h8000_0000;
                default: return 32'h7fff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    // Random traffic that swings between filling and draining the list every
    // 40 beats, so both the full and the empty corner get hit repeatedly.
    task automatic run_traffic_phase(input int unsigned n_items, input int unsigned idle,
                                     input int unsigned stall);
        int unsigned        n;
        int unsigned        roll;
        bit                 filling;
        cmd_t               op;
        logic [FIELD_W-1:0] key;
        send_idle_pct = idle;
        stall_pct     = stall;
        for (n = 0; n < n_items; n++)
        begin
            filling = ((n / 40) % 2) == 0;
            roll    = $urandom_range(99);
            key     = pick_key();
            if (roll < 3)
                op = CMD_NOP;
            else if (roll < (filling ? 75 : 30))
                op = CMD_INSERT;
            else if (roll < (filling ? 85 : 60))
                op = CMD_REMOVE;
            else
                op = CMD_POP;
            if (op == CMD_INSERT)
            begin
                recent_keys[recent_wr % LIST_DEPTH] = key;
                recent_wr++;
            end
            else if (op == CMD_REMOVE && recent_wr != 0 && $urandom_range(99) < 60)
                key = recent_keys[$urandom_range(LIST_DEPTH - 1) % (recent_wr < LIST_DEPTH ?
                                                                   recent_wr : LIST_DEPTH)];
            offer_cmd(op, key, $urandom());
        end
    endtask

    // Response side: random stalls per phase, plus one long hold-off on
    // request so the result register backs up and the block stalls its input.
    initial
    begin : rsp_side
        int unsigned hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = 90;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin : cmd_side
        int unsigned i;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        rst_n          = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list corners first.
        offer_cmd(CMD_POP, 32'd0, 32'd0);
        offer_cmd(CMD_REMOVE, 32'd9, 32'd0);
        offer_cmd(CMD_NOP, '1, '1);
        // Field extremes, then equal keys that must leave in arrival order.
        offer_cmd(CMD_INSERT, 32'd0, 32'd0);
        offer_cmd(CMD_INSERT, '1, '1);
        offer_cmd(CMD_INSERT, 32'd5, 32'd1);
        offer_cmd(CMD_INSERT, 32'd5, 32'd2);
        offer_cmd(CMD_INSERT, 32'd5, 32'd3);
        offer_cmd(CMD_REMOVE, 32'd5, 32'd0);
        offer_cmd(CMD_REMOVE, 32'd1234, 32'd0);
        offer_cmd(CMD_POP, 32'd0, 32'd0);
        offer_cmd(CMD_NOP, 32'd0, 32'd0);
        // Fill to the brim with falling keys, each landing ahead of the one before.
        for (i = 0; i < 13; i++)
            offer_cmd(CMD_INSERT, 32'd100 - i, 32'ha5a5_0000 + i);
        offer_cmd(CMD_INSERT, 32'd3, 32'd77);

        // Random phases. The first also carries the long receiver hold-off.
        hold_request = 1'b1;
        run_traffic_phase(332, 0, 0);
        run_traffic_phase(332, 48, 0);
        run_traffic_phase(332, 0, 48);
        run_traffic_phase(332, 13, 13);

        // Drop valid at the last accepting edge, then drain.
        cmd_ch.valid <= 1'b0;
        stall_pct = 0;
        @(negedge clk);
        while (answers_owed != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/sspq_pkg.sv
hw/rtl/sspq_cmd_if.sv
hw/rtl/sspq_rsp_if.sv
hw/rtl/sspq_cell.sv
hw/rtl/stable_sorted_priority_queue_top.sv
tb/sorted_queue_checker.sv
tb/stable_sorted_priority_queue_top_tb.sv
